@@ hw/rtl/relay_actuator_position_controller_core_defines.svh @@
// Assertion macros for the relay actuator position controller.
// Each macro expects aclk and aresetn in the scope where it is used.
`ifndef RELAY_ACTUATOR_POSITION_CONTROLLER_CORE_DEFINES_SVH
`define RELAY_ACTUATOR_POSITION_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication.
`define RAPC_ASSERT_HOLDS(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define RAPC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/rapc_pkg.sv @@
package rapc_pkg;

    // Motor / relay state codes
    typedef enum logic [1:0] {
        MOTOR_OFF  = 2'd0,
        MOTOR_DOWN = 2'd1,
        MOTOR_UP   = 2'd2
    } motor_t;

    // Item function codes
    localparam logic [1:0] FUNC_HANDLE = 2'd0;
    localparam logic [1:0] FUNC_TARGET = 2'd1;
    localparam logic [1:0] FUNC_STOP   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ON    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERTRAVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS = 3'd4;

    localparam int CFG_DATA_W = 16;
    localparam int POS_W      = 14;

    localparam logic [POS_W-1:0] FULL_SCALE = 14'd10000;

    localparam logic [15:0] TRAVEL_RESET     = 16'd10000;
    localparam logic [15:0] MIN_ON_RESET     = 16'd600;
    localparam logic [15:0] MIN_OFF_RESET    = 16'd800;
    localparam logic [15:0] OVERTRAVEL_RESET = 16'd2000;

    // Serial divider for the position update; the divisor is the travel time
    localparam int DVD_W    = 30;
    localparam int DVS_W    = 16;
    localparam int DIV_CNT_W = $clog2(DVD_W);

    // Divide by full scale: drop four bits (divide by 16), then multiply by
    // the reciprocal of 625 and keep the bits from RECIP_SHIFT up
    localparam int          RECIP_SHIFT = 36;
    localparam int          RECIP_W     = DVD_W + 23;
    localparam logic [26:0] RECIP_625   = 27'd109951163;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ hw/rtl/rapc_div.sv @@
module rapc_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  rapc_pkg::div_req_t req,
    output rapc_pkg::div_rsp_t rsp
);
    import rapc_pkg::*;

    logic [DVD_W-1:0]     dvd_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             q_bit;
    logic [DVS_W-1:0] rem_step;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        q_bit    = (trial >= {1'b0, dvs_reg});
        rem_step = q_bit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= rem_step;
                dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

@@ hw/rtl/relay_actuator_position_controller_core.sv @@
// A position update (retarget while running, or a turn-off) runs one pass of the serial
//   divider unless the run already covers the full travel time; the stop check uses a
//   reciprocal multiply instead of the divider.
// One item at a time: ready again once the result is in the output register, later
//   while the output register is held.
// Reset (aresetn low, synchronous): registers back to defaults, motor off, position
//   and target 0, time counters 0, output register empty.
`include "relay_actuator_position_controller_core_defines.svh"

module relay_actuator_position_controller_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [rapc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rapc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    // Input item stream
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [31:0]                            s_tdata,  // elapsed_ms, target_hundredths
    input  logic [1:0]                             s_tuser,  // func
    // Result item stream
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // relay_up, relay_down, motor_state[2], requested_state[2], position[14],
    // target_position[14], zero pad
    output logic [39:0]                            m_tdata
);
    import rapc_pkg::*;

    localparam int CMP_W = (TIME_WIDTH > 17) ? TIME_WIDTH : 17;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHANGE,
        ST_UPD_RUN,
        ST_UPD_DIV,
        ST_UPD_APPLY,
        ST_STOP_RUN,
        ST_STOP_DIV,
        ST_STOP_CHK,
        ST_SET_PEND,
        ST_DONE
    } seq_t;

    seq_t state_reg;

    // Configuration
    logic [15:0] travel_reg;
    logic [15:0] min_on_reg;
    logic [15:0] min_off_reg;
    logic [15:0] over_reg;

    // Controller state
    logic [TIME_WIDTH-1:0] time_now_reg;
    logic [TIME_WIDTH-1:0] last_chg_reg;
    logic [TIME_WIDTH-1:0] last_pos_reg;
    motor_t                applied_reg;
    motor_t                pending_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      goal_reg;

    // Sequencer scratch
    logic [POS_W-1:0] delta_reg;
    logic             upd_to_off_reg;   // update is part of switching off
    logic [DVD_W-1:0] prod_reg;         // travel * distance for the stop check
    logic [15:0]      need_q_reg;       // travel * distance / full scale

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    // Serial divider for the position update
    div_req_t div_req;
    div_rsp_t div_rsp;

    rapc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Input field views
    logic [15:0]        in_elapsed;
    logic signed [15:0] in_target;
    logic [1:0]         in_func;
    logic               in_accept;

    assign in_elapsed = s_tdata[15:0];
    assign in_target  = s_tdata[31:16];
    assign in_func    = s_tuser;
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;

    // Datapath
    logic [TIME_WIDTH-1:0] run;
    logic [TIME_WIDTH-1:0] held;
    logic                  run_full;
    logic [POS_W-1:0]      distance;
    logic [15:0]           mul_a;
    logic [15:0]           mul_b;
    logic [DVD_W-1:0]      product;
    logic [RECIP_W-1:0]    recip_prod;
    logic [16:0]           need;
    logic                  goal_at_end;
    logic                  run_ge_need;
    logic [POS_W:0]        pos_sum;
    logic [POS_W-1:0]      pos_upd;
    logic [POS_W-1:0]      tgt_clamp;
    logic [POS_W-1:0]      start_clip;
    logic                  stop_sel;

    always_comb begin
        run      = time_now_reg - last_pos_reg;
        held     = time_now_reg - last_chg_reg;
        run_full = (travel_reg == '0) || (run >= TIME_WIDTH'(travel_reg));
        distance = (goal_reg > pos_reg) ? (goal_reg - pos_reg) : (pos_reg - goal_reg);

        // One multiplier: run*full_scale for the divider or travel*distance
        stop_sel = (state_reg == ST_STOP_RUN);
        mul_a    = stop_sel ? travel_reg : run[15:0];
        mul_b    = stop_sel ? 16'(distance) : 16'(FULL_SCALE);
        product  = DVD_W'(mul_a) * DVD_W'(mul_b);

        div_req.start    = (state_reg == ST_UPD_RUN) && !run_full;
        div_req.dividend = product;
        div_req.divisor  = travel_reg;

        // Divide the registered product by full scale without the divider
        recip_prod = RECIP_W'(prod_reg[DVD_W-1:4]) * RECIP_W'(RECIP_625);

        // Stop check: required run time, with overtravel at the end limits
        goal_at_end = (goal_reg == '0) || (goal_reg == FULL_SCALE);
        need        = 17'(need_q_reg) + (goal_at_end ? 17'(over_reg) : 17'd0);
        run_ge_need = (CMP_W'(run) >= CMP_W'(need));

        // Position step, clipped to the travel range
        pos_sum = {1'b0, pos_reg} + {1'b0, delta_reg};
        if (applied_reg == MOTOR_UP) begin
            pos_upd = (pos_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : pos_sum[POS_W-1:0];
        end else begin
            pos_upd = (delta_reg >= pos_reg) ? '0 : (pos_reg - delta_reg);
        end

        if (in_target[15]) begin
            tgt_clamp = '0;
        end else if (in_target[14:0] > 15'(FULL_SCALE)) begin
            tgt_clamp = FULL_SCALE;
        end else begin
            tgt_clamp = in_target[POS_W-1:0];
        end

        start_clip = (cfg_wdata[POS_W-1:0] > FULL_SCALE) ? FULL_SCALE : cfg_wdata[POS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            travel_reg     <= TRAVEL_RESET;
            min_on_reg     <= MIN_ON_RESET;
            min_off_reg    <= MIN_OFF_RESET;
            over_reg       <= OVERTRAVEL_RESET;
            time_now_reg   <= '0;
            last_chg_reg   <= '0;
            last_pos_reg   <= '0;
            applied_reg    <= MOTOR_OFF;
            pending_reg    <= MOTOR_OFF;
            pos_reg        <= '0;
            goal_reg       <= '0;
            upd_to_off_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            // Drop the result once taken; a new load below takes priority
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // Configuration writes must arrive only while idle; the block does not enforce this
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_TRAVEL:     travel_reg  <= cfg_wdata;
                    CFG_MIN_ON:     min_on_reg  <= cfg_wdata;
                    CFG_MIN_OFF:    min_off_reg <= cfg_wdata;
                    CFG_OVERTRAVEL: over_reg    <= cfg_wdata;
                    CFG_START_POS: begin
                        pos_reg  <= start_clip;
                        goal_reg <= start_clip;
                    end
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        time_now_reg   <= time_now_reg + TIME_WIDTH'(in_elapsed);
                        upd_to_off_reg <= 1'b0;
                        case (in_func)
                            FUNC_HANDLE: state_reg <= ST_CHANGE;
                            FUNC_TARGET: begin
                                goal_reg  <= tgt_clamp;
                                state_reg <= (applied_reg != MOTOR_OFF) ? ST_UPD_RUN
                                                                        : ST_SET_PEND;
                            end
                            FUNC_STOP: begin
                                pending_reg <= MOTOR_OFF;
                                state_reg   <= ST_DONE;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_CHANGE: begin
                    state_reg <= ST_STOP_RUN;
                    if (applied_reg != pending_reg) begin
                        if (applied_reg == MOTOR_OFF) begin
                            // Switch on once the minimum off time has passed
                            if (held >= TIME_WIDTH'(min_off_reg)) begin
                                applied_reg  <= pending_reg;
                                last_pos_reg <= time_now_reg;
                                last_chg_reg <= time_now_reg;
                            end
                        end else if (held >= TIME_WIDTH'(min_on_reg)) begin
                            // Stop or reversal: switch off first, after a final update
                            upd_to_off_reg <= 1'b1;
                            state_reg      <= ST_UPD_RUN;
                        end
                    end
                end
                ST_UPD_RUN: begin
                    last_pos_reg <= time_now_reg;
                    if (run_full) begin
                        delta_reg <= FULL_SCALE;
                        state_reg <= ST_UPD_APPLY;
                    end else begin
                        state_reg <= ST_UPD_DIV;
                    end
                end
                ST_UPD_DIV: begin
                    if (div_rsp.done) begin
                        delta_reg <= div_rsp.quotient[POS_W-1:0];
                        state_reg <= ST_UPD_APPLY;
                    end
                end
                ST_UPD_APPLY: begin
                    pos_reg <= pos_upd;
                    if (upd_to_off_reg) begin
                        goal_reg     <= pos_upd;
                        applied_reg  <= MOTOR_OFF;
                        last_chg_reg <= time_now_reg;
                        state_reg    <= ST_DONE;
                    end else begin
                        state_reg <= ST_SET_PEND;
                    end
                end
                ST_STOP_RUN: begin
                    if (applied_reg == MOTOR_OFF) begin
                        state_reg <= ST_DONE;
                    end else begin
                        prod_reg  <= product;
                        state_reg <= ST_STOP_DIV;
                    end
                end
                ST_STOP_DIV: begin
                    need_q_reg <= recip_prod[RECIP_SHIFT +: 16];
                    state_reg  <= ST_STOP_CHK;
                end
                ST_STOP_CHK: begin
                    if (run_ge_need) begin
                        pending_reg <= MOTOR_OFF;
                    end
                    state_reg <= ST_DONE;
                end
                ST_SET_PEND: begin
                    if ((goal_reg > pos_reg) || (goal_reg >= FULL_SCALE)) begin
                        pending_reg <= MOTOR_UP;
                    end else if ((goal_reg < pos_reg) || (goal_reg == '0)) begin
                        pending_reg <= MOTOR_DOWN;
                    end else begin
                        pending_reg <= MOTOR_OFF;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    // Hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {6'd0, goal_reg, pos_reg, pending_reg, applied_reg,
                                         (applied_reg == MOTOR_DOWN),
                                         (applied_reg == MOTOR_UP)};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `RAPC_ASSERT_NEXT(a_busy_after_accept, in_accept, !s_tready, "item taken while busy")
    `RAPC_ASSERT_HOLDS(a_pos_range, 1'b1, (pos_reg <= FULL_SCALE) && (goal_reg <= FULL_SCALE), "position out of range")
    `RAPC_ASSERT_HOLDS(a_relays_exclusive, m_tvalid, !(m_tdata[0] && m_tdata[1]), "both relays driven")
    `RAPC_ASSERT_NEXT(a_result_loaded, (state_reg == ST_DONE) && (!m_tvalid || m_tready), m_tvalid, "result not loaded")

endmodule

@@ sim/tb_relay_actuator_position_controller_core.sv @@
`timescale 1ns / 100ps

module tb_relay_actuator_position_controller_core;
    import rapc_pkg::*;

    localparam int unsigned SCALE = FULL_SCALE;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int STALL_CYCLES = 700;
    localparam int TAIL_CYCLES = 60;

    // One command as it travels on the input stream
    typedef struct {
        logic [1:0]  func;
        logic [15:0] elapsed;
        logic [15:0] target;
    } cmd_t;

    // Relay status as it comes back on the result stream
    typedef struct {
        logic        up;
        logic        down;
        logic [1:0]  motor;
        logic [1:0]  req;
        logic [13:0] pos;
        logic [13:0] goal;
    } status_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    relay_actuator_position_controller_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Stimulus bookkeeping
    cmd_t    pending_cmds[$];
    status_t expected_status[$];
    int      cmds_queued = 0;
    int      items_accepted = 0;
    int      results_checked = 0;
    int      mismatches = 0;
    int      settings_run = 0;
    int      cycles = 0;

    // Idling control: calm flags turn the random gaps off for a stretch
    bit      send_calm = 1'b0;
    bit      recv_calm = 1'b0;
    int      send_wait = 0;
    int      recv_wait = 0;
    int      stall_orders = 0;
    int      stall_taken = 0;
    int      hold_left = 0;

    // Controller model: settings and state
    int unsigned travel_ms, on_min_ms, off_min_ms, overtravel_ms;
    logic [31:0] clock_ms, switch_stamp_ms, pos_stamp_ms;
    motor_t      motor, wanted;
    int unsigned pos, goal;
    int          motor_starts = 0;
    int          reversals = 0;
    int          stop_arrivals = 0;

    // Integrate run time into the tracked position and restart the run clock.
    function automatic void advance_position();
        logic [31:0] run;
        int unsigned delta;
        run = clock_ms - pos_stamp_ms;
        pos_stamp_ms = clock_ms;
        if (motor == MOTOR_OFF) return;
        if (travel_ms == 0 || run >= travel_ms)
            delta = SCALE;
        else
            delta = int'((64'(run) * SCALE) / travel_ms);
        if (motor == MOTOR_UP) begin
            pos = (pos + delta > SCALE) ? SCALE : pos + delta;
        end else begin
            pos = (delta >= pos) ? 0 : pos - delta;
        end
    endfunction

    function automatic void switch_motor(motor_t nxt);
        if (nxt == motor) return;
        if (motor != MOTOR_OFF && nxt == MOTOR_OFF) begin
            advance_position();
            goal = pos;
        end else if (motor == MOTOR_OFF && nxt != MOTOR_OFF) begin
            pos_stamp_ms = clock_ms;
            motor_starts++;
        end
        motor = nxt;
        switch_stamp_ms = clock_ms;
    endfunction

    // Apply the requested state once the relay protection interval has passed.
    function automatic void protect_relays();
        logic [31:0] held;
        held = clock_ms - switch_stamp_ms;
        if (motor == wanted) return;
        if (wanted == MOTOR_OFF) begin
            if (held < on_min_ms) return;
        end else if (motor == MOTOR_OFF) begin
            if (held < off_min_ms) return;
        end else begin
            // reversal: switch off first, the new direction stays requested
            if (held < on_min_ms) return;
            switch_motor(MOTOR_OFF);
            reversals++;
            return;
        end
        switch_motor(wanted);
    endfunction

    // Request off once the run time covers the distance to the goal.
    function automatic void check_arrival();
        logic [31:0] run;
        int unsigned distance;
        logic [63:0] need;
        if (motor == MOTOR_OFF) return;
        run = clock_ms - pos_stamp_ms;
        distance = (goal > pos) ? goal - pos : pos - goal;
        need = (64'(travel_ms) * distance) / SCALE;
        if (goal == 0 || goal == SCALE) need += overtravel_ms;
        if (64'(run) >= need && wanted != MOTOR_OFF) begin
            wanted = MOTOR_OFF;
            stop_arrivals++;
        end
    endfunction

    function automatic void retarget(logic [15:0] raw);
        int t;
        t = int'($signed(raw));
        if (t < 0) t = 0;
        if (t > int'(SCALE)) t = int'(SCALE);
        goal = t;
        if (motor != MOTOR_OFF) advance_position();
        if (goal > pos || goal >= SCALE)
            wanted = MOTOR_UP;
        else if (goal < pos || goal == 0)
            wanted = MOTOR_DOWN;
        else
            wanted = MOTOR_OFF;
    endfunction

    // Run one accepted command through the model and queue the status it causes.
    function automatic void step_controller(logic [1:0] func, logic [31:0] data);
        status_t st;
        clock_ms = clock_ms + data[15:0];
        case (func)
            FUNC_HANDLE: begin
                protect_relays();
                check_arrival();
            end
            FUNC_TARGET: retarget(data[31:16]);
            FUNC_STOP:   wanted = MOTOR_OFF;
            default: ;
        endcase
        st.up = (motor == MOTOR_UP);
        st.down = (motor == MOTOR_DOWN);
        st.motor = motor;
        st.req = wanted;
        st.pos = pos[13:0];
        st.goal = goal[13:0];
        expected_status.push_back(st);
    endfunction

    function automatic void check_status(logic [39:0] data);
        status_t want;
        if (expected_status.size() == 0) begin
            $error("status item with no expectation: %h", data);
            mismatches++;
            return;
        end
        want = expected_status.pop_front();
        results_checked++;
        if (data[0] !== want.up) begin
            $error("relay_up: expected %0d, got %0d", want.up, data[0]);
            mismatches++;
        end
        if (data[1] !== want.down) begin
            $error("relay_down: expected %0d, got %0d", want.down, data[1]);
            mismatches++;
        end
        if (data[3:2] !== want.motor) begin
            $error("motor_state: expected %0d, got %0d", want.motor, data[3:2]);
            mismatches++;
        end
        if (data[5:4] !== want.req) begin
            $error("requested_state: expected %0d, got %0d", want.req, data[5:4]);
            mismatches++;
        end
        if (data[19:6] !== want.pos) begin
            $error("position: expected %0d, got %0d", want.pos, data[19:6]);
            mismatches++;
        end
        if (data[33:20] !== want.goal) begin
            $error("target_position: expected %0d, got %0d", want.goal, data[33:20]);
            mismatches++;
        end
        if (data[39:34] !== 6'd0) begin
            $error("pad: expected 0, got %0d", data[39:34]);
            mismatches++;
        end
    endfunction

    // Driver: offer queued commands, with a random gap drawn after each item.
    always @(posedge aclk) begin
        cmd_t nxt;
        logic offering;
        if (aresetn) begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                step_controller(s_tuser, s_tdata);
                items_accepted++;
                offering = 1'b0;
                send_wait = send_calm ? 0 : $urandom_range(0, 17);
            end
            if (!offering) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_cmds.size() > 0) begin
                    nxt = pending_cmds.pop_front();
                    s_tdata <= {nxt.target, nxt.elapsed};
                    s_tuser <= nxt.func;
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
        end
    end

    // Monitor: check each status item; hold off ready at random, and for a long
    // stretch on request so the block backs up into its input.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_status(m_tdata);
                recv_wait = recv_calm ? 0 : $urandom_range(0, 17);
            end else if (recv_wait > 0) begin
                recv_wait--;
            end
            if (stall_orders != stall_taken) begin
                stall_taken = stall_orders;
                hold_left = STALL_CYCLES;
            end else if (hold_left > 0) begin
                hold_left--;
            end
            m_tready <= (recv_wait == 0 && hold_left == 0);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("relay_actuator_position_controller_core verification failed");
            $finish;
        end
    end

    function automatic void queue_cmd(logic [1:0] func, logic [15:0] elapsed,
                                      logic [15:0] target);
        cmd_t c;
        c.func = func;
        c.elapsed = elapsed;
        c.target = target;
        pending_cmds.push_back(c);
        if (func != FUNC_UNUSED) cmds_queued++;
    endfunction

    function automatic logic [15:0] pick_elapsed(int step_max);
        if ($urandom_range(0, 99) < 5) return 16'($urandom());
        return 16'($urandom_range(0, step_max));
    endfunction

    function automatic logic [15:0] pick_target();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(0, SCALE));
        if (r < 80) return 16'd0;
        if (r < 90) return 16'(SCALE);
        return 16'($urandom());
    endfunction

    // Mostly whole moves: a target followed by periodic handling, with the odd
    // stop or retarget mid-move; the rest is noise.
    task automatic queue_moves(int n, int step_max);
        int stop_at;
        int x;
        stop_at = cmds_queued + n;
        while (cmds_queued < stop_at) begin
            if ($urandom_range(0, 99) < 80) begin
                queue_cmd(FUNC_TARGET, pick_elapsed(step_max), pick_target());
                repeat ($urandom_range(2, 25)) begin
                    x = $urandom_range(0, 99);
                    if (x < 4)
                        queue_cmd(FUNC_STOP, pick_elapsed(step_max), 16'($urandom()));
                    else if (x < 9)
                        queue_cmd(FUNC_TARGET, pick_elapsed(step_max), pick_target());
                    else
                        queue_cmd(FUNC_HANDLE, pick_elapsed(step_max), 16'($urandom()));
                end
            end else begin
                x = $urandom_range(0, 3);
                queue_cmd(2'(x), 16'($urandom()), 16'($urandom()));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Write one register and mirror it into the model.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_TRAVEL:     travel_ms = value;
            CFG_MIN_ON:     on_min_ms = value;
            CFG_MIN_OFF:    off_min_ms = value;
            CFG_OVERTRAVEL: overtravel_ms = value;
            CFG_START_POS: begin
                pos = (value[13:0] > SCALE) ? SCALE : value[13:0];
                goal = pos;
            end
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure(int travel, int on_ms, int off_ms, int over, int start);
        wait_idle();
        write_reg(CFG_TRAVEL, 16'(travel));
        write_reg(CFG_MIN_ON, 16'(on_ms));
        write_reg(CFG_MIN_OFF, 16'(off_ms));
        write_reg(CFG_OVERTRAVEL, 16'(over));
        write_reg(CFG_START_POS, 16'(start));
        settings_run++;
    endtask

    initial begin
        int travel;
        travel_ms = TRAVEL_RESET;
        on_min_ms = MIN_ON_RESET;
        off_min_ms = MIN_OFF_RESET;
        overtravel_ms = OVERTRAVEL_RESET;
        clock_ms = '0;
        switch_stamp_ms = '0;
        pos_stamp_ms = '0;
        motor = MOTOR_OFF;
        wanted = MOTOR_OFF;
        pos = 0;
        goal = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings: field extremes, every function,
        // the unused function code, reversal, stop, long run time.
        settings_run++;
        queue_cmd(FUNC_HANDLE, 16'd0, 16'd0);
        queue_cmd(FUNC_UNUSED, 16'hFFFF, 16'hFFFF);
        queue_cmd(FUNC_TARGET, 16'd10, 16'h7FFF);
        queue_cmd(FUNC_HANDLE, 16'd100, 16'h0000);
        queue_cmd(FUNC_HANDLE, 16'd300, 16'hFFFF);
        queue_cmd(FUNC_TARGET, 16'd200, 16'd3000);
        queue_cmd(FUNC_HANDLE, 16'd100, 16'd0);
        queue_cmd(FUNC_HANDLE, 16'd500, 16'd0);
        queue_cmd(FUNC_HANDLE, 16'd900, 16'd0);
        queue_cmd(FUNC_STOP, 16'd10, 16'h8000);
        queue_cmd(FUNC_HANDLE, 16'd700, 16'd0);
        queue_cmd(FUNC_TARGET, 16'd0, 16'h8000);
        queue_cmd(FUNC_HANDLE, 16'd1000, 16'd0);
        queue_cmd(FUNC_HANDLE, 16'hFFFF, 16'd0);
        queue_cmd(FUNC_HANDLE, 16'd0, 16'd0);
        queue_cmd(FUNC_TARGET, 16'd5, 16'd10000);
        queue_cmd(FUNC_HANDLE, 16'hFFFF, 16'd0);
        queue_cmd(FUNC_HANDLE, 16'hFFFF, 16'd0);
        queue_cmd(FUNC_TARGET, 16'd5, 16'hFFFF);
        queue_cmd(FUNC_TARGET, 16'd5, 16'd10001);
        queue_cmd(FUNC_HANDLE, 16'd2000, 16'd0);
        queue_cmd(FUNC_HANDLE, 16'd40000, 16'd0);
        queue_cmd(FUNC_UNUSED, 16'd1, 16'd0);
        queue_moves(110, 400);

        // Shortest travel, no protection, start at the top
        configure(1, 0, 0, 0, SCALE);
        send_calm = 1'b1;
        recv_calm = 1'b1;
        queue_moves(120, 3);

        // Timing registers at their maximum, start position 0
        configure(65535, 65535, 65535, 65535, 0);
        send_calm = 1'b0;
        queue_moves(120, 9000);

        // Zero travel duration, start position above full scale
        configure(0, 600, 800, 2000, 16'h3FFF);
        recv_calm = 1'b0;
        queue_moves(120, 300);

        // Mid start, target equal to position; long receiver hold-off while
        // the sender keeps offering
        configure(2500, 100, 50, 500, 5000);
        send_calm = 1'b1;
        queue_cmd(FUNC_TARGET, 16'd3, 16'd5000);
        queue_cmd(FUNC_HANDLE, 16'd100, 16'd0);
        queue_moves(140, 150);
        stall_orders++;
        repeat (STALL_CYCLES / 2) @(posedge aclk);
        send_calm = 1'b0;

        // Random settings
        repeat (2) begin
            travel = $urandom_range(1, 20000);
            configure(travel, $urandom_range(0, 2000), $urandom_range(0, 2000),
                      $urandom_range(0, 3000), $urandom_range(0, SCALE));
            queue_moves(110, travel / 15 + 1);
        end

        // Back to reset values; start register with all bits set
        configure(TRAVEL_RESET, MIN_ON_RESET, MIN_OFF_RESET, OVERTRAVEL_RESET, 16'hFFFF);
        queue_moves(80, 400);

        wait_idle();
        $display("ran %0d items over %0d register settings, %0d status items checked",
                 items_accepted, settings_run, results_checked);
        $display("motor started %0d times, %0d reversals, %0d stops at target",
                 motor_starts, reversals, stop_arrivals);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("relay_actuator_position_controller_core verification clean");
        end else begin
            $display("relay_actuator_position_controller_core verification failed");
        end
        $finish;
    end

endmodule
